@@ rtl/bir_pkg.sv @@
// Shared types and constants for the bilinear image resize core.
package bir_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 25;
    localparam int SIZE_W      = 9;
    localparam int STEP_W      = 25;
    localparam int COORD_W     = 8;
    localparam int CHAN_W      = 2;
    localparam int PIXEL_W     = 8;
    localparam int RESULT_W    = 16;

    localparam int PROD_W  = 34;
    localparam int POS_W   = PROD_W - 1;
    localparam int FRAC_W  = 16;
    localparam int INT_W   = POS_W - FRAC_W;
    localparam int WEIGHT_W = FRAC_W + 1;
    localparam int BLEND_W = PIXEL_W + FRAC_W;
    localparam int ACC_W   = BLEND_W + FRAC_W;

    localparam logic [POS_W-1:0]    HALF_PIXEL = POS_W'(32768);
    localparam logic [WEIGHT_W-1:0] FRAC_ONE   = WEIGHT_W'(65536);
    localparam logic [ACC_W-1:0]    ROUND_BIAS = ACC_W'(8388608);

    localparam logic [SIZE_W-1:0] RST_SOURCE_SIZE = SIZE_W'(1);
    localparam logic [STEP_W-1:0] RST_STEP        = STEP_W'(65536);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_X_STEP        = 3'd2,
        CFG_Y_STEP        = 3'd3,
        CFG_INTERP_MODE   = 3'd4
    } cfg_index_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic {
        INTERP_NEAREST  = 1'b0,
        INTERP_BILINEAR = 1'b1
    } interp_t;

endpackage

@@ rtl/bilinear_image_resize_core.sv @@
// Top level of the bilinear image resize core: image store and query pipeline.

// Each input word is either a load, which writes one source pixel into the
// image store, or a query, which maps a destination column and row to the
// source image and returns one 8.8 intensity, blended from four neighbours
// or taken from the nearest pixel. The block takes one word per cycle
// while the output is not stalled, and returns one result per query;
// loads give no result. The eight register stages are: step multiply,
// source position, edge clamp, store read, neighbour select, horizontal
// blend, vertical blend, rounding. The store is split into four banks by
// column and row parity, each with one port, so the four neighbours are read
// together; each bank holds MAX_WIDTH/2 x MAX_HEIGHT/2 x MAX_CHANNELS pixels,
// rounded up to a power of two. Store contents are undefined until loaded.
// Write configuration only when the block is idle; cfg_ready is always high.
module bilinear_image_resize_core #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bir_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bir_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [bir_pkg::COORD_W-1:0]       s_column,
    input  logic [bir_pkg::COORD_W-1:0]       s_row_index,
    input  logic [bir_pkg::CHAN_W-1:0]        s_channel,
    input  logic [bir_pkg::PIXEL_W-1:0]       s_pixel_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bir_pkg::RESULT_W-1:0]      m_result_value
);
    import bir_pkg::*;

    localparam int XB = $clog2(MAX_WIDTH);
    localparam int YB = $clog2(MAX_HEIGHT);
    localparam int XH = (XB > 1) ? XB - 1 : 1;
    localparam int YH = (YB > 1) ? YB - 1 : 1;
    localparam int CB = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int EH = $clog2(MAX_HEIGHT + 1);
    localparam int ADDR_W = YH + XH + CB;
    localparam int BANK_DEPTH = 1 << ADDR_W;
    localparam int NUM_STAGES = 8;

    // configuration
    logic [SIZE_W-1:0] source_width_reg;
    logic [SIZE_W-1:0] source_height_reg;
    logic [STEP_W-1:0] x_step_reg;
    logic [STEP_W-1:0] y_step_reg;
    interp_t           interp_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_width_reg  <= RST_SOURCE_SIZE;
            source_height_reg <= RST_SOURCE_SIZE;
            x_step_reg        <= RST_STEP;
            y_step_reg        <= RST_STEP;
            interp_mode_reg   <= INTERP_BILINEAR;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SOURCE_WIDTH:  source_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_SOURCE_HEIGHT: source_height_reg <= cfg_data[SIZE_W-1:0];
                CFG_X_STEP:        x_step_reg        <= cfg_data[STEP_W-1:0];
                CFG_Y_STEP:        y_step_reg        <= cfg_data[STEP_W-1:0];
                CFG_INTERP_MODE:   interp_mode_reg   <= interp_t'(cfg_data[0]);
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic [EW-1:0] w_eff;
    logic [EH-1:0] h_eff;
    logic [XB-1:0] x_last;
    logic [YB-1:0] y_last;
    logic          nearest;

    always_comb begin
        if (source_width_reg == '0) begin
            w_eff = EW'(1);
        end else if (int'(source_width_reg) > MAX_WIDTH) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(source_width_reg);
        end
        if (source_height_reg == '0) begin
            h_eff = EH'(1);
        end else if (int'(source_height_reg) > MAX_HEIGHT) begin
            h_eff = EH'(MAX_HEIGHT);
        end else begin
            h_eff = EH'(source_height_reg);
        end
        x_last  = XB'(w_eff - EW'(1));
        y_last  = YB'(h_eff - EH'(1));
        nearest = (interp_mode_reg == INTERP_NEAREST);
    end

    // stage valids and advance chain
    logic [NUM_STAGES:1] vld_reg;
    logic [NUM_STAGES:1] vld_next;
    logic [NUM_STAGES:1] adv;

    // stage 1: step multiply
    op_t                s1_op_reg;
    logic [COORD_W-1:0] s1_x_reg;
    logic [COORD_W-1:0] s1_y_reg;
    logic [CB-1:0]      s1_ch_reg;
    logic [PIXEL_W-1:0] s1_pix_reg;
    logic               s1_wr_ok_reg;
    logic [PROD_W-1:0]  s1_px_reg;
    logic [PROD_W-1:0]  s1_py_reg;
    logic [CB-1:0]      s1_ch_next;
    logic               s1_wr_ok_next;
    logic [PROD_W-1:0]  s1_px_next;
    logic [PROD_W-1:0]  s1_py_next;

    // stage 2: source position
    op_t                s2_op_reg;
    logic [COORD_W-1:0] s2_x_reg;
    logic [COORD_W-1:0] s2_y_reg;
    logic [CB-1:0]      s2_ch_reg;
    logic [PIXEL_W-1:0] s2_pix_reg;
    logic               s2_wr_ok_reg;
    logic [INT_W-1:0]   s2_ix_reg;
    logic [INT_W-1:0]   s2_iy_reg;
    logic [FRAC_W-1:0]  s2_fx_reg;
    logic [FRAC_W-1:0]  s2_fy_reg;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   src_x;
    logic [POS_W-1:0]   src_y;
    logic [INT_W-1:0]   s2_ix_next;
    logic [INT_W-1:0]   s2_iy_next;
    logic [FRAC_W-1:0]  s2_fx_next;
    logic [FRAC_W-1:0]  s2_fy_next;

    // stage 3: edge clamp
    op_t                s3_op_reg;
    logic [CB-1:0]      s3_ch_reg;
    logic [PIXEL_W-1:0] s3_pix_reg;
    logic               s3_wr_ok_reg;
    logic [XB-1:0]      s3_x0_reg;
    logic [XB-1:0]      s3_x1_reg;
    logic [YB-1:0]      s3_y0_reg;
    logic [YB-1:0]      s3_y1_reg;
    logic [FRAC_W-1:0]  s3_fx_reg;
    logic [FRAC_W-1:0]  s3_fy_reg;
    logic [INT_W:0]     x_inc;
    logic [INT_W:0]     y_inc;
    logic [XB-1:0]      x_lo;
    logic [XB-1:0]      x_hi;
    logic [YB-1:0]      y_lo;
    logic [YB-1:0]      y_hi;
    logic [XB-1:0]      s3_x0_next;
    logic [XB-1:0]      s3_x1_next;
    logic [YB-1:0]      s3_y0_next;
    logic [YB-1:0]      s3_y1_next;

    // stage 4: store read
    logic [PIXEL_W-1:0] store_mem [4][BANK_DEPTH];
    logic [PIXEL_W-1:0] bank_rd_reg [4];
    logic [ADDR_W-1:0]  bank_addr [4];
    logic [3:0]         bank_we;
    logic               s4_xp_reg;
    logic               s4_yp_reg;
    logic               s4_xsame_reg;
    logic               s4_ysame_reg;
    logic [FRAC_W-1:0]  s4_fx_reg;
    logic [FRAC_W-1:0]  s4_fy_reg;

    // stage 5: neighbour select
    logic [PIXEL_W-1:0] s5_p00_reg;
    logic [PIXEL_W-1:0] s5_p10_reg;
    logic [PIXEL_W-1:0] s5_p01_reg;
    logic [PIXEL_W-1:0] s5_p11_reg;
    logic [FRAC_W-1:0]  s5_fx_reg;
    logic [FRAC_W-1:0]  s5_fy_reg;
    logic [PIXEL_W-1:0] row0_near;
    logic [PIXEL_W-1:0] row0_far;
    logic [PIXEL_W-1:0] row1_near;
    logic [PIXEL_W-1:0] row1_far;
    logic [PIXEL_W-1:0] s5_p00_next;
    logic [PIXEL_W-1:0] s5_p10_next;
    logic [PIXEL_W-1:0] s5_p01_next;
    logic [PIXEL_W-1:0] s5_p11_next;

    // stage 6: horizontal blend
    logic [BLEND_W-1:0]  s6_top_reg;
    logic [BLEND_W-1:0]  s6_bot_reg;
    logic [FRAC_W-1:0]   s6_fy_reg;
    logic [WEIGHT_W-1:0] gx;
    logic [BLEND_W:0]    top_sum;
    logic [BLEND_W:0]    bot_sum;

    // stage 7: vertical blend
    logic [ACC_W-1:0]    s7_acc_reg;
    logic [WEIGHT_W-1:0] gy;
    logic [ACC_W-1:0]    s7_acc_next;

    // stage 8: rounding
    logic [RESULT_W-1:0] s8_result_reg;
    logic [ACC_W-1:0]    rounded;

    always_comb begin
        adv[NUM_STAGES] = !vld_reg[NUM_STAGES] || m_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (adv[1]) begin
            vld_next[1] = s_valid;
        end
        for (int k = 2; k <= NUM_STAGES; k++) begin
            if (adv[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
        if (adv[4]) begin
            vld_next[4] = vld_reg[3] && (s3_op_reg == OP_QUERY);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = adv[1];

    always_comb begin
        s1_wr_ok_next = (int'(s_column) < MAX_WIDTH) && (int'(s_row_index) < MAX_HEIGHT)
                        && (int'(s_channel) < MAX_CHANNELS);
        if (int'(s_channel) >= MAX_CHANNELS) begin
            s1_ch_next = CB'(MAX_CHANNELS - 1);
        end else begin
            s1_ch_next = CB'(s_channel);
        end
        s1_px_next = PROD_W'({s_column, 1'b1}) * PROD_W'(x_step_reg);
        s1_py_next = PROD_W'({s_row_index, 1'b1}) * PROD_W'(y_step_reg);
    end

    always_comb begin
        pos_x = s1_px_reg[PROD_W-1:1];
        pos_y = s1_py_reg[PROD_W-1:1];
        src_x = (pos_x >= HALF_PIXEL) ? pos_x - HALF_PIXEL : '0;
        src_y = (pos_y >= HALF_PIXEL) ? pos_y - HALF_PIXEL : '0;
        if (nearest) begin
            s2_ix_next = pos_x[POS_W-1:FRAC_W];
            s2_iy_next = pos_y[POS_W-1:FRAC_W];
            s2_fx_next = '0;
            s2_fy_next = '0;
        end else begin
            s2_ix_next = src_x[POS_W-1:FRAC_W];
            s2_iy_next = src_y[POS_W-1:FRAC_W];
            s2_fx_next = src_x[FRAC_W-1:0];
            s2_fy_next = src_y[FRAC_W-1:0];
        end
    end

    always_comb begin
        x_inc = {1'b0, s2_ix_reg} + (INT_W+1)'(1);
        y_inc = {1'b0, s2_iy_reg} + (INT_W+1)'(1);
        x_lo  = (s2_ix_reg >= INT_W'(w_eff)) ? x_last : XB'(s2_ix_reg);
        y_lo  = (s2_iy_reg >= INT_W'(h_eff)) ? y_last : YB'(s2_iy_reg);
        x_hi  = (x_inc >= (INT_W+1)'(w_eff)) ? x_last : XB'(x_inc);
        y_hi  = (y_inc >= (INT_W+1)'(h_eff)) ? y_last : YB'(y_inc);
        if (s2_op_reg == OP_LOAD) begin
            s3_x0_next = XB'(s2_x_reg);
            s3_x1_next = XB'(s2_x_reg);
            s3_y0_next = YB'(s2_y_reg);
            s3_y1_next = YB'(s2_y_reg);
        end else if (nearest) begin
            s3_x0_next = x_lo;
            s3_x1_next = x_lo;
            s3_y0_next = y_lo;
            s3_y1_next = y_lo;
        end else begin
            s3_x0_next = x_lo;
            s3_x1_next = x_hi;
            s3_y0_next = y_lo;
            s3_y1_next = y_hi;
        end
    end

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            logic [XB-1:0] xs;
            logic [YB-1:0] ys;
            xs = (s3_x0_reg[0] == b[0]) ? s3_x0_reg : s3_x1_reg;
            ys = (s3_y0_reg[0] == b[1]) ? s3_y0_reg : s3_y1_reg;
            bank_addr[b] = {YH'(ys >> 1), XH'(xs >> 1), s3_ch_reg};
            bank_we[b]   = adv[4] && vld_reg[3] && (s3_op_reg == OP_LOAD) && s3_wr_ok_reg
                           && (s3_x0_reg[0] == b[0]) && (s3_y0_reg[0] == b[1]);
        end
    end

    always_ff @(posedge aclk) begin
        for (int b = 0; b < 4; b++) begin
            if (bank_we[b]) begin
                store_mem[b][bank_addr[b]] <= s3_pix_reg;
            end
            if (adv[4]) begin
                bank_rd_reg[b] <= store_mem[b][bank_addr[b]];
            end
        end
    end

    always_comb begin
        row0_near = s4_xp_reg ? bank_rd_reg[1] : bank_rd_reg[0];
        row0_far  = s4_xp_reg ? bank_rd_reg[0] : bank_rd_reg[1];
        row1_near = s4_xp_reg ? bank_rd_reg[3] : bank_rd_reg[2];
        row1_far  = s4_xp_reg ? bank_rd_reg[2] : bank_rd_reg[3];
        s5_p00_next = s4_yp_reg ? row1_near : row0_near;
        s5_p10_next = s4_xsame_reg ? s5_p00_next : (s4_yp_reg ? row1_far : row0_far);
        s5_p01_next = s4_ysame_reg ? s5_p00_next : (s4_yp_reg ? row0_near : row1_near);
        if (s4_ysame_reg) begin
            s5_p11_next = s5_p10_next;
        end else if (s4_xsame_reg) begin
            s5_p11_next = s5_p01_next;
        end else begin
            s5_p11_next = s4_yp_reg ? row0_far : row1_far;
        end
    end

    always_comb begin
        gx = FRAC_ONE - WEIGHT_W'(s5_fx_reg);
        top_sum = (BLEND_W+1)'(s5_p00_reg) * (BLEND_W+1)'(gx)
                + (BLEND_W+1)'(s5_p10_reg) * (BLEND_W+1)'(s5_fx_reg);
        bot_sum = (BLEND_W+1)'(s5_p01_reg) * (BLEND_W+1)'(gx)
                + (BLEND_W+1)'(s5_p11_reg) * (BLEND_W+1)'(s5_fx_reg);
    end

    always_comb begin
        gy = FRAC_ONE - WEIGHT_W'(s6_fy_reg);
        s7_acc_next = ACC_W'(s6_top_reg) * ACC_W'(gy) + ACC_W'(s6_bot_reg) * ACC_W'(s6_fy_reg);
        rounded = s7_acc_reg + ROUND_BIAS;
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s1_op_reg    <= op_t'(s_operation);
            s1_x_reg     <= s_column;
            s1_y_reg     <= s_row_index;
            s1_ch_reg    <= s1_ch_next;
            s1_pix_reg   <= s_pixel_value;
            s1_wr_ok_reg <= s1_wr_ok_next;
            s1_px_reg    <= s1_px_next;
            s1_py_reg    <= s1_py_next;
        end
        if (adv[2]) begin
            s2_op_reg    <= s1_op_reg;
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            s2_ch_reg    <= s1_ch_reg;
            s2_pix_reg   <= s1_pix_reg;
            s2_wr_ok_reg <= s1_wr_ok_reg;
            s2_ix_reg    <= s2_ix_next;
            s2_iy_reg    <= s2_iy_next;
            s2_fx_reg    <= s2_fx_next;
            s2_fy_reg    <= s2_fy_next;
        end
        if (adv[3]) begin
            s3_op_reg    <= s2_op_reg;
            s3_ch_reg    <= s2_ch_reg;
            s3_pix_reg   <= s2_pix_reg;
            s3_wr_ok_reg <= s2_wr_ok_reg;
            s3_x0_reg    <= s3_x0_next;
            s3_x1_reg    <= s3_x1_next;
            s3_y0_reg    <= s3_y0_next;
            s3_y1_reg    <= s3_y1_next;
            s3_fx_reg    <= s2_fx_reg;
            s3_fy_reg    <= s2_fy_reg;
        end
        if (adv[4]) begin
            s4_xp_reg    <= s3_x0_reg[0];
            s4_yp_reg    <= s3_y0_reg[0];
            s4_xsame_reg <= (s3_x1_reg == s3_x0_reg);
            s4_ysame_reg <= (s3_y1_reg == s3_y0_reg);
            s4_fx_reg    <= s3_fx_reg;
            s4_fy_reg    <= s3_fy_reg;
        end
        if (adv[5]) begin
            s5_p00_reg <= s5_p00_next;
            s5_p10_reg <= s5_p10_next;
            s5_p01_reg <= s5_p01_next;
            s5_p11_reg <= s5_p11_next;
            s5_fx_reg  <= s4_fx_reg;
            s5_fy_reg  <= s4_fy_reg;
        end
        if (adv[6]) begin
            s6_top_reg <= top_sum[BLEND_W-1:0];
            s6_bot_reg <= bot_sum[BLEND_W-1:0];
            s6_fy_reg  <= s5_fy_reg;
        end
        if (adv[7]) begin
            s7_acc_reg <= s7_acc_next;
        end
        if (adv[8]) begin
            s8_result_reg <= rounded[ACC_W-1 -: RESULT_W];
        end
    end

    assign m_valid        = vld_reg[NUM_STAGES];
    assign m_result_value = s8_result_reg;

endmodule

@@ rtl/bir_port_checker.sv @@
// Port-level assertions for the bilinear image resize core, bound to the top level.
module bir_port_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [bir_pkg::RESULT_W-1:0]  m_result_value
);
    import bir_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value))
        else $error("result word changed or dropped while stalled");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled while output stage is free");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_min_latency: assert property (@(posedge aclk)
        !aresetn |=> ##6 !m_valid)
        else $error("result appeared faster than the pipeline depth");

endmodule

bind bilinear_image_resize_core bir_port_checker u_bir_port_checker (.*);

@@ test/bir_scaler_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the bilinear image resize core: predicts each query result and compares it.
module bir_scaler_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [bir_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bir_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_operation,
    input  logic [bir_pkg::COORD_W-1:0]     s_column,
    input  logic [bir_pkg::COORD_W-1:0]     s_row_index,
    input  logic [bir_pkg::CHAN_W-1:0]      s_channel,
    input  logic [bir_pkg::PIXEL_W-1:0]     s_pixel_value,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [bir_pkg::RESULT_W-1:0]    m_result_value,
    output int                              failures,
    output int                              outstanding
);
    import bir_pkg::*;

    localparam int IMAGE_LIMIT = 256;
    localparam int ACC_MSB     = ACC_W + 1;

    logic [PIXEL_W-1:0]  image_copy [0:2**(2*COORD_W+CHAN_W)-1];
    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;
    logic [STEP_W-1:0]   x_step_reg;
    logic [STEP_W-1:0]   y_step_reg;
    interp_t             mode_reg;
    logic [RESULT_W-1:0] expected_pixels [$];
    logic [RESULT_W-1:0] oldest_pixel;

    task automatic report_mismatch(input string what);
        $display("%0t ERROR %s", $time, what);
        failures++;
    endtask

    function automatic logic [SIZE_W-1:0] active_size(input logic [SIZE_W-1:0] reg_value);
        if (reg_value == 0) begin
            return SIZE_W'(1);
        end
        if (reg_value > IMAGE_LIMIT) begin
            return SIZE_W'(IMAGE_LIMIT);
        end
        return reg_value;
    endfunction

    function automatic logic [POS_W-1:0] source_position(input logic [COORD_W-1:0] dst,
                                                         input logic [STEP_W-1:0] step);
        logic [PROD_W-1:0] prod;
        logic [POS_W-1:0]  half;
        prod = (PROD_W'(dst) * 2 + 1) * PROD_W'(step);
        half = prod[PROD_W-1:1];
        return (half < HALF_PIXEL) ? '0 : half - HALF_PIXEL;
    endfunction

    function automatic logic [COORD_W-1:0] edge_clamp(input logic [POS_W:0] v,
                                                      input logic [SIZE_W-1:0] size);
        return (v >= (POS_W+1)'(size)) ? COORD_W'(size - 1) : v[COORD_W-1:0];
    endfunction

    function automatic logic [RESULT_W-1:0] scaled_pixel(input logic [COORD_W-1:0] col,
                                                         input logic [COORD_W-1:0] row,
                                                         input logic [CHAN_W-1:0] ch);
        logic [SIZE_W-1:0]   w;
        logic [SIZE_W-1:0]   h;
        logic [POS_W-1:0]    sx;
        logic [POS_W-1:0]    sy;
        logic [COORD_W-1:0]  x0;
        logic [COORD_W-1:0]  x1;
        logic [COORD_W-1:0]  y0;
        logic [COORD_W-1:0]  y1;
        logic [WEIGHT_W-1:0] fx;
        logic [WEIGHT_W-1:0] fy;
        logic [WEIGHT_W-1:0] gx;
        logic [WEIGHT_W-1:0] gy;
        logic [ACC_MSB:0]    acc;
        w = active_size(width_reg);
        h = active_size(height_reg);
        sx = source_position(col, x_step_reg);
        sy = source_position(row, y_step_reg);
        if (mode_reg == INTERP_NEAREST) begin
            x0 = edge_clamp(({1'b0, sx} + (POS_W+1)'(HALF_PIXEL)) >> FRAC_W, w);
            y0 = edge_clamp(({1'b0, sy} + (POS_W+1)'(HALF_PIXEL)) >> FRAC_W, h);
            return {image_copy[{y0, x0, ch}], 8'h00};
        end
        fx = WEIGHT_W'(sx[FRAC_W-1:0]);
        fy = WEIGHT_W'(sy[FRAC_W-1:0]);
        gx = FRAC_ONE - fx;
        gy = FRAC_ONE - fy;
        x0 = edge_clamp({1'b0, sx} >> FRAC_W, w);
        y0 = edge_clamp({1'b0, sy} >> FRAC_W, h);
        x1 = edge_clamp((POS_W+1)'(x0) + (POS_W+1)'(1), w);
        y1 = edge_clamp((POS_W+1)'(y0) + (POS_W+1)'(1), h);
        acc = (ACC_MSB+1)'(image_copy[{y0, x0, ch}]) * (ACC_MSB+1)'(gx) * (ACC_MSB+1)'(gy)
            + (ACC_MSB+1)'(image_copy[{y0, x1, ch}]) * (ACC_MSB+1)'(fx) * (ACC_MSB+1)'(gy)
            + (ACC_MSB+1)'(image_copy[{y1, x0, ch}]) * (ACC_MSB+1)'(gx) * (ACC_MSB+1)'(fy)
            + (ACC_MSB+1)'(image_copy[{y1, x1, ch}]) * (ACC_MSB+1)'(fx) * (ACC_MSB+1)'(fy);
        acc = acc + (ACC_MSB+1)'(ROUND_BIAS);
        return acc[2*FRAC_W-PIXEL_W +: RESULT_W];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg = RST_SOURCE_SIZE;
            height_reg = RST_SOURCE_SIZE;
            x_step_reg = RST_STEP;
            y_step_reg = RST_STEP;
            mode_reg = INTERP_BILINEAR;
            failures = 0;
            expected_pixels.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SOURCE_WIDTH:  width_reg = cfg_data[SIZE_W-1:0];
                    CFG_SOURCE_HEIGHT: height_reg = cfg_data[SIZE_W-1:0];
                    CFG_X_STEP:        x_step_reg = cfg_data[STEP_W-1:0];
                    CFG_Y_STEP:        y_step_reg = cfg_data[STEP_W-1:0];
                    CFG_INTERP_MODE:   mode_reg = interp_t'(cfg_data[0]);
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("result word %h with no query pending",
                                              m_result_value));
                end else begin
                    oldest_pixel = expected_pixels.pop_front();
                    if (m_result_value !== oldest_pixel) begin
                        report_mismatch($sformatf("result_value %h, expected %h",
                                                  m_result_value, oldest_pixel));
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_operation == OP_LOAD) begin
                    image_copy[{s_row_index, s_column, s_channel}] = s_pixel_value;
                end else begin
                    expected_pixels.push_back(scaled_pixel(s_column, s_row_index, s_channel));
                end
            end
        end
        outstanding <= expected_pixels.size();
    end

endmodule

@@ test/tb_bilinear_image_resize_core.sv @@
`timescale 1ns / 100ps
// Testbench top for the bilinear image resize core: stimulus, handshake pacing and verdict.
module tb_bilinear_image_resize_core;
    import bir_pkg::*;

    localparam int ITEM_GOAL   = 1450;
    localparam int CALM_ITEMS  = 200;
    localparam int DRAIN_PAUSE = 12;
    localparam int QUIET_LIMIT = 4000;
    localparam int IMAGE_LIMIT = 256;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_operation = 1'b0;
    logic [COORD_W-1:0]     s_column = '0;
    logic [COORD_W-1:0]     s_row_index = '0;
    logic [CHAN_W-1:0]      s_channel = '0;
    logic [PIXEL_W-1:0]     s_pixel_value = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [RESULT_W-1:0]    m_result_value;

    int failures;
    int outstanding;
    int items_sent = 0;
    int send_gap_rate = 0;
    int recv_stall_rate = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int region_w = 1;
    int region_h = 1;
    bit calm = 1'b0;

    bilinear_image_resize_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_column       (s_column),
        .s_row_index    (s_row_index),
        .s_channel      (s_channel),
        .s_pixel_value  (s_pixel_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value)
    );

    bir_scaler_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_column       (s_column),
        .s_row_index    (s_row_index),
        .s_channel      (s_channel),
        .s_pixel_value  (s_pixel_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .failures       (failures),
        .outstanding    (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 15) < recv_stall_rate) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 16);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [PIXEL_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_word(input op_t op, input logic [COORD_W-1:0] col,
                             input logic [COORD_W-1:0] row, input logic [CHAN_W-1:0] ch,
                             input logic [PIXEL_W-1:0] pix);
        if (!calm && $urandom_range(0, 15) < send_gap_rate) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_column <= col;
        s_row_index <= row;
        s_channel <= ch;
        s_pixel_value <= pix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        calm = (items_sent >= ITEM_GOAL - CALM_ITEMS);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] w_reg, input logic [SIZE_W-1:0] h_reg,
                             input logic [STEP_W-1:0] xs, input logic [STEP_W-1:0] ys,
                             input interp_t mode, input logic [3:0] mask, input int n_items,
                             input int span_x, input int span_y);
        int                 pick;
        logic [CHAN_W-1:0]  ch;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        drain_results();
        repeat (DRAIN_PAUSE) @(posedge aclk);
        write_reg(CFG_SOURCE_WIDTH, CFG_DATA_W'(w_reg));
        write_reg(CFG_SOURCE_HEIGHT, CFG_DATA_W'(h_reg));
        write_reg(CFG_X_STEP, CFG_DATA_W'(xs));
        write_reg(CFG_Y_STEP, CFG_DATA_W'(ys));
        write_reg(CFG_INTERP_MODE, CFG_DATA_W'(mode));
        cfg_valid <= 1'b0;
        region_w = (w_reg == 0) ? 1 : ((w_reg > IMAGE_LIMIT) ? IMAGE_LIMIT : int'(w_reg));
        region_h = (h_reg == 0) ? 1 : ((h_reg > IMAGE_LIMIT) ? IMAGE_LIMIT : int'(h_reg));
        // fill the visible image for every channel that gets queried
        for (int c = 0; c < 4; c++) begin
            if (mask[c]) begin
                for (int r = 0; r < region_h; r++) begin
                    for (int x = 0; x < region_w; x++) begin
                        send_word(OP_LOAD, COORD_W'(x), COORD_W'(r), CHAN_W'(c),
                                  pick_pixel());
                    end
                end
            end
        end
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            ch = CHAN_W'($urandom_range(0, 3));
            while (!mask[ch]) ch = CHAN_W'($urandom_range(0, 3));
            if (pick < 60) begin
                col = ($urandom_range(0, 6) == 0) ? COORD_W'($urandom_range(0, 255))
                                                  : COORD_W'($urandom_range(0, span_x));
                row = ($urandom_range(0, 6) == 0) ? COORD_W'($urandom_range(0, 255))
                                                  : COORD_W'($urandom_range(0, span_y));
                send_word(OP_QUERY, col, row, ch, PIXEL_W'($urandom_range(0, 255)));
            end else if (pick < 80) begin
                send_word(OP_LOAD, COORD_W'($urandom_range(0, region_w - 1)),
                          COORD_W'($urandom_range(0, region_h - 1)), ch, pick_pixel());
            end else if (pick < 96) begin
                send_word(OP_LOAD, COORD_W'($urandom), COORD_W'($urandom), CHAN_W'($urandom),
                          PIXEL_W'($urandom));
            end else begin
                drain_results();
            end
        end
    endtask

    initial begin
        logic [SIZE_W-1:0] w_reg;
        logic [SIZE_W-1:0] h_reg;
        logic [STEP_W-1:0] xs;
        logic [STEP_W-1:0] ys;
        int                span_x;
        int                span_y;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(OP_LOAD, 8'd0, 8'd0, 2'd0, 8'h00);
        send_word(OP_LOAD, 8'd0, 8'd0, 2'd1, 8'hff);
        send_word(OP_LOAD, 8'd0, 8'd0, 2'd2, 8'h5a);
        send_word(OP_LOAD, 8'd0, 8'd0, 2'd3, 8'ha5);
        send_word(OP_LOAD, 8'd255, 8'd255, 2'd3, 8'hff);
        send_word(OP_LOAD, 8'd255, 8'd0, 2'd2, 8'h00);
        send_word(OP_LOAD, 8'd0, 8'd255, 2'd1, 8'h81);
        send_word(OP_QUERY, 8'd0, 8'd0, 2'd0, 8'hff);
        send_word(OP_QUERY, 8'd0, 8'd0, 2'd1, 8'h00);
        send_word(OP_QUERY, 8'd0, 8'd0, 2'd2, 8'hff);
        send_word(OP_QUERY, 8'd0, 8'd0, 2'd3, 8'h00);
        send_word(OP_QUERY, 8'd255, 8'd255, 2'd3, 8'hff);
        send_word(OP_QUERY, 8'd255, 8'd0, 2'd1, 8'h00);
        send_word(OP_QUERY, 8'd0, 8'd255, 2'd2, 8'hff);
        send_word(OP_QUERY, 8'd128, 8'd64, 2'd0, 8'h00);

        // zero step and upscale below the first pixel, nearest pick
        run_phase(9'd4, 9'd3, 25'd0, 25'd16384, INTERP_NEAREST, 4'b0101, 16, 4, 12);
        // widest source, step of 256: all but column 0 land past the right edge
        run_phase(9'd256, 9'd1, 25'd16777216, 25'd16777216, INTERP_BILINEAR, 4'b1000,
                  12, 3, 3);
        // tallest source, nearest pick
        run_phase(9'd1, 9'd256, 25'd65536, 25'd32768, INTERP_NEAREST, 4'b0010, 12, 4, 255);
        // size registers out of range: width above maximum, height zero
        run_phase(9'd511, 9'd0, 25'd21845, 25'd65536, INTERP_BILINEAR, 4'b0001, 12, 255, 3);

        while (items_sent < ITEM_GOAL) begin
            send_gap_rate = $urandom_range(0, 4);
            recv_stall_rate = $urandom_range(0, 4);
            w_reg = SIZE_W'($urandom_range(1, 6));
            h_reg = SIZE_W'($urandom_range(1, 6));
            if ($urandom_range(0, 5) == 0) begin
                w_reg = SIZE_W'($urandom_range(7, 20));
                h_reg = SIZE_W'($urandom_range(1, 2));
            end
            span_x = $urandom_range(1, 24);
            span_y = $urandom_range(1, 24);
            xs = STEP_W'((int'(w_reg) * 65536) / span_x);
            ys = STEP_W'((int'(h_reg) * 65536) / span_y);
            if ($urandom_range(0, 4) == 0) begin
                xs = STEP_W'($urandom_range(0, 196608));
            end
            if ($urandom_range(0, 4) == 0) begin
                ys = STEP_W'($urandom_range(0, 196608));
            end
            run_phase(w_reg, h_reg, xs, ys, interp_t'($urandom_range(0, 1)),
                      4'($urandom_range(1, 15)), $urandom_range(40, 90), span_x, span_y);
        end

        drain_results();
        repeat (DRAIN_PAUSE) @(posedge aclk);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
